@@ hw/rtl/pnst_pkg.sv @@
// Shared constants, types and codes of the per-node send token table.
`default_nettype none

package pnst_pkg;

   localparam int TABLE_ENTRIES  = 64;
   localparam int NODE_ID_BITS   = 16;
   localparam int OBJECT_ID_BITS = 32;

   localparam int IDX_W      = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int USED_W     = 7;
   localparam int LIMIT_W    = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_INDEX_W = 1;

   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W      = $clog2(GROUP_SIZE + 1);

   localparam logic               RESET_PER_NODE_LIMIT = 1'b1;
   localparam logic [LIMIT_W-1:0] RESET_TOKEN_LIMIT    = 7'd2;

   typedef logic [NODE_ID_BITS-1:0]   node_type;
   typedef logic [OBJECT_ID_BITS-1:0] obj_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [COUNT_W-1:0]        cnt_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESERVE = 3'd0,
      MODE_FREE    = 3'd1,
      MODE_EXISTS  = 3'd2,
      MODE_AVAIL   = 3'd3,
      MODE_LIST    = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_GLOBAL  = 3'd1,
      ST_HELD    = 3'd2,
      ST_NODE    = 3'd3,
      ST_MISSING = 3'd4,
      ST_IGNORED = 3'd5,
      ST_FULL    = 3'd6
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PER_NODE_LIMIT = 1'b0,
      CSR_TOKEN_LIMIT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      node_type node;
      obj_type  obj;
   } entry_type;

   typedef struct packed {
      logic    flag;
      obj_type obj;
   } list_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic     cmp_en;
      node_type cmp_node;
      obj_type  cmp_obj;
      node_type wr_node;
      obj_type  wr_obj;
      cnt_type  total;
      idx_type  where;
      logic     append_en;
      logic     remove_en;
      logic     list_load;
      logic     list_shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/pnst_if.sv @@
// Request and response channel interfaces of the send token table.
`default_nettype none

interface pnst_req_if;
   import pnst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   node_type              node_id;
   obj_type               object_id;

   modport source (output valid, output mode, output node_id, output object_id,
                   input ready);
   modport sink   (input valid, input mode, input node_id, input object_id,
                   output ready);
endinterface

interface pnst_rsp_if;
   import pnst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic                  token_free;
   logic                  pair_held;
   logic [USED_W-1:0]     node_tokens_used;
   logic [USED_W-1:0]     total_tokens_used;
   obj_type               listed_object;
   logic                  listed_valid;
   logic                  last;

   modport source (output valid, output status, output token_free, output pair_held,
                   output node_tokens_used, output total_tokens_used,
                   output listed_object, output listed_valid, output last,
                   input ready);
   modport sink   (input valid, input status, input token_free, input pair_held,
                   input node_tokens_used, input total_tokens_used,
                   input listed_object, input listed_valid, input last,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/per_node_send_token_table_unit.sv @@
// Per-node send token table: a row of entry cells with a sequencing controller.
// A non-list transaction runs registered steps in order: compare in the cells at
// acceptance, group count, total count, execute (held until the response register
// is free). A new transaction is taken only in idle; a list shifts its chain one
// cell per cycle toward the output end, stalling on a flagged cell until it is taken.
// Reset (synchronous, active high) empties the table and restores the limits.
`default_nettype none

module per_node_send_token_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   pnst_req_if.sink                            req_chan,
   pnst_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [pnst_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pnst_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pnst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GROUP,
      S_SUM,
      S_EXEC,
      S_LIST
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic               per_node_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Captured request.
   logic [MODE_W-1:0]  op_ff, op_in;
   node_type           node_ff, node_in;
   obj_type            obj_ff, obj_in;

   // Table occupancy and list progress.
   cnt_type            total_ff, total_in;
   cnt_type            left_ff, left_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_free_ff, rsp_free_in;
   logic               rsp_held_ff, rsp_held_in;
   logic [USED_W-1:0]  rsp_nused_ff, rsp_nused_in;
   logic [USED_W-1:0]  rsp_tused_ff, rsp_tused_in;
   obj_type            rsp_obj_ff, rsp_obj_in;
   logic               rsp_lvalid_ff, rsp_lvalid_in;
   logic               rsp_last_ff, rsp_last_in;

   // Cell row.
   cell_ctl_type              ctl;
   entry_type                 entry_out [TABLE_ENTRIES];
   entry_type                 nbr_entry [TABLE_ENTRIES];
   list_type                  list_out  [TABLE_ENTRIES];
   list_type                  list_in   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]  match_node;
   logic [TABLE_ENTRIES-1:0]  match_pair;

   cnt_type            node_count;
   logic               pair_found;
   idx_type            pair_where;

   logic               accept;
   logic               out_free;
   logic [USED_W-1:0]  cnt7;
   logic [USED_W-1:0]  tot7;
   list_type           list_top;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   // The response register can take a new transaction when empty or draining.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign cnt7           = USED_W'(node_count);
   assign tot7           = USED_W'(total_ff);
   assign list_top       = list_out[TABLE_ENTRIES-1];

   // Row of cells: removal pulls entries down from the next cell up, a listing
   // pushes flagged objects up toward the last cell, which faces the output.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      if (i == TABLE_ENTRIES - 1) begin : g_top
         assign nbr_entry[i] = entry_out[i];
      end else begin : g_mid
         assign nbr_entry[i] = entry_out[i+1];
      end
      if (i == 0) begin : g_bottom
         assign list_in[i] = '0;
      end else begin : g_up
         assign list_in[i] = list_out[i-1];
      end

      pnst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .ctl        (ctl),
         .nbr_entry  (nbr_entry[i]),
         .list_in    (list_in[i]),
         .entry_out  (entry_out[i]),
         .list_out   (list_out[i]),
         .match_node (match_node[i]),
         .match_pair (match_pair[i])
      );
   end

   pnst_count u_count (
      .clock      (clock),
      .match_node (match_node),
      .match_pair (match_pair),
      .node_count (node_count),
      .pair_found (pair_found),
      .pair_where (pair_where)
   );

   // User must send configuration writes only while the table is idle; unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         per_node_ff <= RESET_PER_NODE_LIMIT;
         limit_ff    <= RESET_TOKEN_LIMIT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PER_NODE_LIMIT: per_node_ff <= csr_wdata[0];
            CSR_TOKEN_LIMIT:    limit_ff    <= LIMIT_W'(csr_wdata);
            default:            ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      node_in       = node_ff;
      obj_in        = obj_ff;
      total_in      = total_ff;
      left_in       = left_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_nused_in  = rsp_nused_ff;
      rsp_tused_in  = rsp_tused_ff;
      rsp_obj_in    = rsp_obj_ff;
      rsp_lvalid_in = rsp_lvalid_ff;
      rsp_last_in   = rsp_last_ff;

      // Compare against the bus during acceptance, so the match bits are
      // registered and ready in the cycle after acceptance.
      ctl.cmp_en     = accept;
      ctl.cmp_node   = req_chan.node_id;
      ctl.cmp_obj    = req_chan.object_id;
      ctl.wr_node    = node_ff;
      ctl.wr_obj     = obj_ff;
      ctl.total      = total_ff;
      ctl.where      = pair_where;
      ctl.append_en  = 1'b0;
      ctl.remove_en  = 1'b0;
      ctl.list_load  = 1'b0;
      ctl.list_shift = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.mode;
               node_in  = req_chan.node_id;
               obj_in   = req_chan.object_id;
               state_in = S_GROUP;
            end
         end

         S_GROUP: state_in = S_SUM;

         S_SUM: state_in = S_EXEC;

         S_EXEC: begin
            // Hold until the response register is free.
            if (out_free) begin
               rsp_status_in = ST_OK;
               rsp_free_in   = 1'b0;
               rsp_held_in   = 1'b0;
               rsp_nused_in  = cnt7;
               rsp_obj_in    = '0;
               rsp_lvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;

               case (op_ff)
                  MODE_RESERVE: begin
                     if (!per_node_ff && (tot7 >= limit_ff)) begin
                        rsp_status_in = ST_GLOBAL;
                     end else if (pair_found) begin
                        rsp_status_in = ST_HELD;
                     end else if (cnt7 >= limit_ff) begin
                        rsp_status_in = ST_NODE;
                     end else if (total_ff == COUNT_W'(TABLE_ENTRIES)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.append_en = 1'b1;
                        total_in      = total_ff + COUNT_W'(1);
                        rsp_nused_in  = cnt7 + USED_W'(1);
                     end
                  end
                  MODE_FREE: begin
                     if (node_ff == '0) begin
                        rsp_status_in = ST_IGNORED;
                     end else if (!pair_found) begin
                        rsp_status_in = ST_MISSING;
                     end else begin
                        ctl.remove_en = 1'b1;
                        total_in      = total_ff - COUNT_W'(1);
                        rsp_nused_in  = cnt7 - USED_W'(1);
                     end
                  end
                  MODE_EXISTS: rsp_held_in = pair_found;
                  MODE_AVAIL: begin
                     rsp_free_in = per_node_ff ? (cnt7 < limit_ff) : (tot7 < limit_ff);
                  end
                  MODE_LIST: begin
                     // An empty listing answers at once; otherwise load the
                     // list chain and drop the single response.
                     if (node_count != '0) begin
                        ctl.list_load = 1'b1;
                        left_in       = node_count;
                        rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
                        rsp_status_in = rsp_status_ff;
                        rsp_nused_in  = rsp_nused_ff;
                        rsp_last_in   = rsp_last_ff;
                        state_in      = S_LIST;
                     end
                  end
                  default: rsp_status_in = ST_IGNORED;
               endcase
               rsp_tused_in = USED_W'(total_in);
            end
         end

         S_LIST: begin
            // Advance past unflagged cells; stall on a flagged one until the
            // response register takes it.
            ctl.list_shift = !list_top.flag || out_free;
            if (list_top.flag && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_free_in   = 1'b0;
               rsp_held_in   = 1'b0;
               rsp_nused_in  = cnt7;
               rsp_tused_in  = tot7;
               rsp_obj_in    = list_top.obj;
               rsp_lvalid_in = 1'b1;
               rsp_last_in   = (left_ff == COUNT_W'(1));
               left_in       = left_ff - COUNT_W'(1);
               if (left_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
      end
      op_ff         <= op_in;
      node_ff       <= node_in;
      obj_ff        <= obj_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_nused_ff  <= rsp_nused_in;
      rsp_tused_ff  <= rsp_tused_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_lvalid_ff <= rsp_lvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.token_free        = rsp_free_ff;
   assign rsp_chan.pair_held         = rsp_held_ff;
   assign rsp_chan.node_tokens_used  = rsp_nused_ff;
   assign rsp_chan.total_tokens_used = rsp_tused_ff;
   assign rsp_chan.listed_object     = rsp_obj_ff;
   assign rsp_chan.listed_valid      = rsp_lvalid_ff;
   assign rsp_chan.last              = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pnst_cell.sv @@
// One table cell: holds a token entry, compares it, shifts on free and list.
`default_nettype none

module pnst_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pnst_pkg::idx_type     cell_idx,
   input  pnst_pkg::cell_ctl_type ctl,
   input  pnst_pkg::entry_type   nbr_entry,
   input  pnst_pkg::list_type    list_in,
   output pnst_pkg::entry_type   entry_out,
   output pnst_pkg::list_type    list_out,
   output logic                  match_node,
   output logic                  match_pair
);
   import pnst_pkg::*;

   entry_type entry_ff, entry_in;
   list_type  list_ff, list_in_nxt;
   logic      match_node_ff, match_node_in;
   logic      match_pair_ff, match_pair_in;
   logic      valid;

   assign valid = COUNT_W'(cell_idx) < ctl.total;

   always_comb begin
      match_node_in = match_node_ff;
      match_pair_in = match_pair_ff;
      if (ctl.cmp_en) begin
         match_node_in = valid && (entry_ff.node == ctl.cmp_node);
         match_pair_in = match_node_in && (entry_ff.obj == ctl.cmp_obj);
      end

      entry_in = entry_ff;
      if (ctl.append_en && (COUNT_W'(cell_idx) == ctl.total)) begin
         entry_in.node = ctl.wr_node;
         entry_in.obj  = ctl.wr_obj;
      end else if (ctl.remove_en && (cell_idx >= ctl.where)) begin
         entry_in = nbr_entry;
      end

      list_in_nxt = list_ff;
      if (ctl.list_load) begin
         list_in_nxt.flag = match_node_ff;
         list_in_nxt.obj  = entry_ff.obj;
      end else if (ctl.list_shift) begin
         list_in_nxt = list_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_node_ff <= 1'b0;
         match_pair_ff <= 1'b0;
         list_ff.flag  <= 1'b0;
      end else begin
         match_node_ff <= match_node_in;
         match_pair_ff <= match_pair_in;
         list_ff.flag  <= list_in_nxt.flag;
      end
      list_ff.obj <= list_in_nxt.obj;
      entry_ff    <= entry_in;
   end

   assign entry_out  = entry_ff;
   assign list_out   = list_ff;
   assign match_node = match_node_ff;
   assign match_pair = match_pair_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pnst_count.sv @@
// Registered reduction of cell match bits: node count, pair found, pair index.
`default_nettype none

module pnst_count (
   input  logic                                 clock,
   input  logic [pnst_pkg::TABLE_ENTRIES-1:0]   match_node,
   input  logic [pnst_pkg::TABLE_ENTRIES-1:0]   match_pair,
   output pnst_pkg::cnt_type                    node_count,
   output logic                                 pair_found,
   output pnst_pkg::idx_type                    pair_where
);
   import pnst_pkg::*;

   localparam int PAD_W = NUM_GROUPS * GROUP_SIZE;

   logic [PAD_W-1:0] padded;
   logic [GRP_W-1:0] grp_ff [NUM_GROUPS];
   logic [GRP_W-1:0] grp_in [NUM_GROUPS];
   cnt_type          cnt_ff, cnt_in;
   logic             found_ff, found_in;
   idx_type          where_ff, where_in;

   assign padded = PAD_W'(match_node);

   // First stage: per-group popcount, pair flag and pair index.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            grp_in[g] = grp_in[g] + GRP_W'(padded[g*GROUP_SIZE + j]);
         end
      end
      found_in = |match_pair;
      // at most one valid entry holds a given pair
      where_in = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         where_in = where_in | (match_pair[i] ? IDX_W'(i) : '0);
      end
   end

   // Second stage: sum the groups.
   always_comb begin
      cnt_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         cnt_in = cnt_in + COUNT_W'(grp_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_ff[g] <= grp_in[g];
      end
      found_ff <= found_in;
      where_ff <= where_in;
      cnt_ff   <= cnt_in;
   end

   assign node_count = cnt_ff;
   assign pair_found = found_ff;
   assign pair_where = where_ff;

endmodule

`default_nettype wire
